[sv/acc_pkg.sv]
// Shared types, constants and helpers for the actuator command controller.
package acc_pkg;

  // Operating modes, as shown on the mode result field
  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_AUTO     = 2'd1,
    MODE_MANUAL   = 2'd2,
    MODE_SHUTDOWN = 2'd3
  } mode_t;

  // Configuration register indexes
  localparam logic CFG_PULSE_TICKS        = 1'b0;
  localparam logic CFG_SHUTDOWN_GAP_TICKS = 1'b1;

  // Reset values of the configuration registers
  localparam logic [15:0] PULSE_TICKS_RESET        = 16'd3000;
  localparam logic [15:0] SHUTDOWN_GAP_TICKS_RESET = 16'd2000;

  // Command characters
  localparam logic [7:0] CH_AUTO        = 8'h4A; // 'J'
  localparam logic [7:0] CH_MANUAL      = 8'h4D; // 'M'
  localparam logic [7:0] CH_EXIT        = 8'h58; // 'X'
  localparam logic [7:0] CH_SET_SUCT    = 8'h53; // 'S'
  localparam logic [7:0] CH_SET_SPIST   = 8'h41; // 'A'
  localparam logic [7:0] CH_SET_LPIST   = 8'h45; // 'E'
  localparam logic [7:0] CH_CLR_SUCT    = 8'h54; // 'T'
  localparam logic [7:0] CH_CLR_SPIST   = 8'h4B; // 'K'
  localparam logic [7:0] CH_CLR_LPIST   = 8'h50; // 'P'

  // Pulse targets (0 means no pulse running)
  localparam logic [1:0] TGT_NONE  = 2'd0;
  localparam logic [1:0] TGT_SUCT  = 2'd1;
  localparam logic [1:0] TGT_SPIST = 2'd2;
  localparam logic [1:0] TGT_LPIST = 2'd3;

  // Shutdown steps
  localparam logic [1:0] SD_NONE  = 2'd0;
  localparam logic [1:0] SD_SPIST = 2'd1;
  localparam logic [1:0] SD_LPIST = 2'd2;

  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_byte;
    logic       suction_on;
    logic       suction_piston_on;
    logic       label_piston_on;
    logic [1:0] mode;
  } out_t;

  typedef struct packed {
    logic [15:0] pulse_ticks;
    logic [15:0] shutdown_gap_ticks;
  } cfg_t;

  typedef struct packed {
    mode_t       mode_state;
    logic [2:0]  actuator_bits;
    logic [15:0] countdown;
    logic [1:0]  pulse_target;
    logic [1:0]  shutdown_step;
  } state_t;

  // S/A/E -> 1..3, anything else 0
  function automatic logic [1:0] set_index(input logic [7:0] c);
    logic [1:0] k;
    begin
      k = TGT_NONE;
      if (c == CH_SET_SUCT) k = TGT_SUCT;
      else if (c == CH_SET_SPIST) k = TGT_SPIST;
      else if (c == CH_SET_LPIST) k = TGT_LPIST;
      return k;
    end
  endfunction

  // T/K/P -> 1..3, anything else 0
  function automatic logic [1:0] clear_index(input logic [7:0] c);
    logic [1:0] k;
    begin
      k = TGT_NONE;
      if (c == CH_CLR_SUCT) k = TGT_SUCT;
      else if (c == CH_CLR_SPIST) k = TGT_SPIST;
      else if (c == CH_CLR_LPIST) k = TGT_LPIST;
      return k;
    end
  endfunction

  // One-hot actuator mask for index 1..3
  function automatic logic [2:0] act_mask(input logic [1:0] k);
    logic [2:0] m;
    begin
      case (k)
        TGT_SUCT:  m = 3'b001;
        TGT_SPIST: m = 3'b010;
        TGT_LPIST: m = 3'b100;
        default:   m = 3'b000;
      endcase
      return m;
    end
  endfunction

  // Letter echoed when a pulse ends
  function automatic logic [7:0] pulse_letter(input logic [1:0] k);
    logic [7:0] c;
    begin
      case (k)
        TGT_SUCT:  c = CH_SET_SUCT;
        TGT_SPIST: c = CH_SET_SPIST;
        TGT_LPIST: c = CH_SET_LPIST;
        default:   c = 8'h00;
      endcase
      return c;
    end
  endfunction

endpackage

[sv/acc_cfg.sv]
// Configuration registers: pulse length and shutdown gap.
module acc_cfg (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_wdata,
  output acc_pkg::cfg_t cfg
);

  // Write port, no read-back
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pulse_ticks        <= acc_pkg::PULSE_TICKS_RESET;
      cfg.shutdown_gap_ticks <= acc_pkg::SHUTDOWN_GAP_TICKS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        acc_pkg::CFG_PULSE_TICKS:        cfg.pulse_ticks        <= cfg_wdata;
        acc_pkg::CFG_SHUTDOWN_GAP_TICKS: cfg.shutdown_gap_ticks <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

[sv/acc_step.sv]
// Per-transaction update: next controller state and the result it produces.
module acc_step (
  input  acc_pkg::state_t state,
  input  acc_pkg::in_t    item,
  input  acc_pkg::cfg_t   cfg,
  output acc_pkg::state_t state_next,
  output acc_pkg::out_t   result
);

  logic [1:0]  set_k;
  logic [1:0]  clr_k;
  logic [15:0] count_dec;
  logic        expired;
  logic        echo;
  logic [7:0]  echo_char;

  assign set_k     = acc_pkg::set_index(item.rx_byte);
  assign clr_k     = acc_pkg::clear_index(item.rx_byte);
  // Running count steps down to zero and sticks there
  assign count_dec = (state.countdown != 16'd0) ? state.countdown - 16'd1 : 16'd0;
  assign expired   = (count_dec == 16'd0);

  // Next state
  always_comb begin
    state_next = state;
    if (!item.cmd) begin
      case (state.mode_state)
        acc_pkg::MODE_IDLE: begin
          if (item.rx_byte == acc_pkg::CH_AUTO) state_next.mode_state = acc_pkg::MODE_AUTO;
          else if (item.rx_byte == acc_pkg::CH_MANUAL)
            state_next.mode_state = acc_pkg::MODE_MANUAL;
        end
        acc_pkg::MODE_AUTO: begin
          if (set_k != acc_pkg::TGT_NONE) begin
            state_next.actuator_bits = state.actuator_bits | acc_pkg::act_mask(set_k);
          end else if (clr_k != acc_pkg::TGT_NONE) begin
            state_next.actuator_bits = state.actuator_bits & ~acc_pkg::act_mask(clr_k);
          end else if (item.rx_byte == acc_pkg::CH_EXIT) begin
            state_next.mode_state = acc_pkg::MODE_IDLE;
          end
        end
        acc_pkg::MODE_MANUAL: begin
          // Bytes during a pulse are dropped
          if (state.pulse_target == acc_pkg::TGT_NONE) begin
            if (set_k != acc_pkg::TGT_NONE) begin
              state_next.actuator_bits = state.actuator_bits | acc_pkg::act_mask(set_k);
              state_next.pulse_target  = set_k;
              state_next.countdown     = cfg.pulse_ticks;
            end else if (item.rx_byte == acc_pkg::CH_EXIT) begin
              state_next.actuator_bits = state.actuator_bits & 3'b110;
              state_next.countdown     = cfg.shutdown_gap_ticks;
              state_next.shutdown_step = acc_pkg::SD_SPIST;
              state_next.mode_state    = acc_pkg::MODE_SHUTDOWN;
            end
          end
        end
        default: ;
      endcase
    end else begin
      // Tick: advance a running pulse or shutdown gap
      if (state.mode_state == acc_pkg::MODE_MANUAL &&
          state.pulse_target != acc_pkg::TGT_NONE) begin
        state_next.countdown = count_dec;
        if (expired) begin
          state_next.actuator_bits =
            state.actuator_bits & ~acc_pkg::act_mask(state.pulse_target);
          state_next.pulse_target = acc_pkg::TGT_NONE;
        end
      end else if (state.mode_state == acc_pkg::MODE_SHUTDOWN) begin
        state_next.countdown = count_dec;
        if (expired) begin
          if (state.shutdown_step == acc_pkg::SD_SPIST) begin
            state_next.actuator_bits = state.actuator_bits & 3'b101;
            state_next.countdown     = cfg.shutdown_gap_ticks;
            state_next.shutdown_step = acc_pkg::SD_LPIST;
          end else begin
            state_next.actuator_bits = state.actuator_bits & 3'b011;
            state_next.shutdown_step = acc_pkg::SD_NONE;
            state_next.mode_state    = acc_pkg::MODE_IDLE;
          end
        end
      end
    end
  end

  // Echo decision
  always_comb begin
    echo      = 1'b0;
    echo_char = item.rx_byte;
    if (!item.cmd) begin
      case (state.mode_state)
        acc_pkg::MODE_IDLE:   echo = 1'b1;
        acc_pkg::MODE_AUTO:   echo = (set_k != acc_pkg::TGT_NONE) ||
                                     (clr_k != acc_pkg::TGT_NONE);
        acc_pkg::MODE_MANUAL: echo = (state.pulse_target == acc_pkg::TGT_NONE) &&
                                     (set_k != acc_pkg::TGT_NONE);
        default:              echo = 1'b0;
      endcase
    end else if (state.mode_state == acc_pkg::MODE_MANUAL &&
                 state.pulse_target != acc_pkg::TGT_NONE && expired) begin
      // Pulse end repeats its letter
      echo      = 1'b1;
      echo_char = acc_pkg::pulse_letter(state.pulse_target);
    end
  end

  // Result fields show the state after the transaction
  always_comb begin
    result.echo_valid        = echo;
    result.echo_byte         = echo ? echo_char : 8'h00;
    result.suction_on        = state_next.actuator_bits[0];
    result.suction_piston_on = state_next.actuator_bits[1];
    result.label_piston_on   = state_next.actuator_bits[2];
    result.mode              = state_next.mode_state;
  end

endmodule

[sv/actuator_command_controller.sv]
// Top level of the actuator command controller: input and result registers.
//
// Usage:
//   Input channel (in_valid/in_ready/in_data): each transaction is either a
//   received command byte (cmd = 0, rx_byte) or a one millisecond tick
//   (cmd = 1). Every input transaction yields exactly one result on the
//   output channel (out_valid/out_ready/out_data): an optional echo byte,
//   the three actuator levels and the mode after the transaction.
//   Result: out_valid rises when the state update loads the result register
//   from the input register. Throughput: one transaction per cycle unless
//   the output stalls; the only loop is the controller state register,
//   updated by one pass of compare-and-select logic.
//   Stalls: while out_ready is low the result register holds its transaction
//   and the input register can still take one more; in_ready then drops
//   until the result is taken.
//   Reset (rst, synchronous): idle mode, all actuators off, no pulse or
//   shutdown running, pulse_ticks = 3000 and shutdown_gap_ticks = 2000.
//   Configuration: cfg_we writes cfg_wdata to register cfg_index
//   (0 pulse_ticks, 1 shutdown_gap_ticks); a new value applies at the next
//   pulse or gap start.
module actuator_command_controller (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  acc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output acc_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_wdata
);

  acc_pkg::cfg_t   cfg;
  acc_pkg::state_t state;
  acc_pkg::state_t state_next;
  acc_pkg::out_t   result;
  acc_pkg::in_t    item;
  logic            item_valid;
  logic            advance;

  acc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  acc_step u_step (
    .state      (state),
    .item       (item),
    .cfg        (cfg),
    .state_next (state_next),
    .result     (result)
  );

  // Move the held transaction into the result register when it is free
  assign advance  = item_valid && (!out_valid || out_ready);
  assign in_ready = !item_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_data;
    end
  end

  // Controller state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.mode_state    <= acc_pkg::MODE_IDLE;
      state.actuator_bits <= 3'b000;
      state.countdown     <= 16'd0;
      state.pulse_target  <= acc_pkg::TGT_NONE;
      state.shutdown_step <= acc_pkg::SD_NONE;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

  // A pulse only runs in manual mode
  a_pulse_in_manual: assert property (@(posedge clk) disable iff (rst)
    state.pulse_target != acc_pkg::TGT_NONE |-> state.mode_state == acc_pkg::MODE_MANUAL)
    else $error("pulse running outside manual mode");

  // Shutdown step is tracked exactly while shutting down
  a_step_in_shutdown: assert property (@(posedge clk) disable iff (rst)
    (state.mode_state == acc_pkg::MODE_SHUTDOWN) == (state.shutdown_step != acc_pkg::SD_NONE))
    else $error("shutdown step out of step with mode");

  // Suction is off throughout the shutdown, suction piston too in its second gap
  a_shutdown_order: assert property (@(posedge clk) disable iff (rst)
    (state.shutdown_step == acc_pkg::SD_LPIST && state.actuator_bits[1:0] != 2'b00) ||
    (state.shutdown_step == acc_pkg::SD_SPIST && state.actuator_bits[0]) |-> 1'b0)
    else $error("shutdown cleared outputs out of order");

  // A transaction moved on is presented on the output next cycle
  a_advance_shows: assert property (@(posedge clk) disable iff (rst)
    advance |=> out_valid && out_data.mode == $past(state_next.mode_state))
    else $error("result register missed a transaction");

endmodule

[bench/tb.sv]
// Self-checking testbench for the actuator command controller.
`timescale 1ns / 100ps

module tb;

  localparam int QUIET_LIMIT  = 2000;  // cycles with no transaction before giving up
  localparam int RANDOM_ITEMS = 1950;
  localparam int DRAIN_CYCLES = 8;     // drain margin after the input and result registers

  localparam logic [7:0] PULSE_CHARS [3] = '{acc_pkg::CH_SET_SUCT, acc_pkg::CH_SET_SPIST,
                                             acc_pkg::CH_SET_LPIST};
  localparam logic [7:0] AUTO_CHARS [6] = '{acc_pkg::CH_SET_SUCT, acc_pkg::CH_SET_SPIST,
                                            acc_pkg::CH_SET_LPIST, acc_pkg::CH_CLR_SUCT,
                                            acc_pkg::CH_CLR_SPIST, acc_pkg::CH_CLR_LPIST};

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_ready;
  acc_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  acc_pkg::out_t out_data;
  logic          cfg_we = 1'b0;
  logic          cfg_index = acc_pkg::CFG_PULSE_TICKS;
  logic [15:0]   cfg_wdata = '0;

  actuator_command_controller dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Predicted controller state, starting from the reset state
  acc_pkg::mode_t ctrl_mode = acc_pkg::MODE_IDLE;
  logic [2:0]     act_bits = 3'b000;
  logic [15:0]    remaining = 16'd0;
  logic [1:0]     pulse_sel = acc_pkg::TGT_NONE;
  logic [1:0]     sd_stage = acc_pkg::SD_NONE;
  logic [15:0]    pulse_len = acc_pkg::PULSE_TICKS_RESET;
  logic [15:0]    gap_len = acc_pkg::SHUTDOWN_GAP_TICKS_RESET;

  acc_pkg::in_t  queued_commands[$];
  acc_pkg::out_t predicted_outputs[$];
  acc_pkg::out_t want;
  int   queued_total = 0;
  int   error_count = 0;
  int   result_count = 0;
  int   gap_left = 0;
  int   stall_left = 0;
  int   next_stall = 0;
  int   quiet_cycles = 0;
  bit   drive_idle = 1'b1;
  bit   accept_idle = 1'b1;

  // Advance the predicted state by one transaction and return the output it shows
  function automatic acc_pkg::out_t advance_controller(acc_pkg::in_t item);
    logic [1:0] set_sel;
    logic [1:0] clr_sel;
    acc_pkg::out_t res;
    res = '0;
    case (item.rx_byte)
      acc_pkg::CH_SET_SUCT:  set_sel = acc_pkg::TGT_SUCT;
      acc_pkg::CH_SET_SPIST: set_sel = acc_pkg::TGT_SPIST;
      acc_pkg::CH_SET_LPIST: set_sel = acc_pkg::TGT_LPIST;
      default:               set_sel = acc_pkg::TGT_NONE;
    endcase
    case (item.rx_byte)
      acc_pkg::CH_CLR_SUCT:  clr_sel = acc_pkg::TGT_SUCT;
      acc_pkg::CH_CLR_SPIST: clr_sel = acc_pkg::TGT_SPIST;
      acc_pkg::CH_CLR_LPIST: clr_sel = acc_pkg::TGT_LPIST;
      default:               clr_sel = acc_pkg::TGT_NONE;
    endcase
    if (!item.cmd) begin
      case (ctrl_mode)
        acc_pkg::MODE_IDLE: begin
          res.echo_valid = 1'b1;
          res.echo_byte = item.rx_byte;
          if (item.rx_byte == acc_pkg::CH_AUTO) ctrl_mode = acc_pkg::MODE_AUTO;
          else if (item.rx_byte == acc_pkg::CH_MANUAL) ctrl_mode = acc_pkg::MODE_MANUAL;
        end
        acc_pkg::MODE_AUTO: begin
          if (set_sel != acc_pkg::TGT_NONE) begin
            act_bits = act_bits | (3'b001 << (set_sel - 2'd1));
            res.echo_valid = 1'b1;
            res.echo_byte = item.rx_byte;
          end else if (clr_sel != acc_pkg::TGT_NONE) begin
            act_bits = act_bits & ~(3'b001 << (clr_sel - 2'd1));
            res.echo_valid = 1'b1;
            res.echo_byte = item.rx_byte;
          end else if (item.rx_byte == acc_pkg::CH_EXIT) begin
            ctrl_mode = acc_pkg::MODE_IDLE;
          end
        end
        acc_pkg::MODE_MANUAL: begin
          // bytes during a running pulse are dropped
          if (pulse_sel == acc_pkg::TGT_NONE) begin
            if (set_sel != acc_pkg::TGT_NONE) begin
              act_bits = act_bits | (3'b001 << (set_sel - 2'd1));
              pulse_sel = set_sel;
              remaining = pulse_len;
              res.echo_valid = 1'b1;
              res.echo_byte = item.rx_byte;
            end else if (item.rx_byte == acc_pkg::CH_EXIT) begin
              act_bits[0] = 1'b0;
              remaining = gap_len;
              sd_stage = acc_pkg::SD_SPIST;
              ctrl_mode = acc_pkg::MODE_SHUTDOWN;
            end
          end
        end
        default: ;
      endcase
    end else if ((ctrl_mode == acc_pkg::MODE_MANUAL && pulse_sel != acc_pkg::TGT_NONE) ||
                 ctrl_mode == acc_pkg::MODE_SHUTDOWN) begin
      // a count of zero expires on the first tick
      if (remaining != 16'd0) remaining = remaining - 16'd1;
      if (remaining == 16'd0) begin
        if (ctrl_mode == acc_pkg::MODE_MANUAL) begin
          act_bits = act_bits & ~(3'b001 << (pulse_sel - 2'd1));
          res.echo_valid = 1'b1;
          case (pulse_sel)
            acc_pkg::TGT_SUCT:  res.echo_byte = acc_pkg::CH_SET_SUCT;
            acc_pkg::TGT_SPIST: res.echo_byte = acc_pkg::CH_SET_SPIST;
            default:            res.echo_byte = acc_pkg::CH_SET_LPIST;
          endcase
          pulse_sel = acc_pkg::TGT_NONE;
        end else if (sd_stage == acc_pkg::SD_SPIST) begin
          act_bits[1] = 1'b0;
          remaining = gap_len;
          sd_stage = acc_pkg::SD_LPIST;
        end else begin
          act_bits[2] = 1'b0;
          sd_stage = acc_pkg::SD_NONE;
          ctrl_mode = acc_pkg::MODE_IDLE;
        end
      end
    end
    res.suction_on = act_bits[0];
    res.suction_piston_on = act_bits[1];
    res.label_piston_on = act_bits[2];
    res.mode = ctrl_mode;
    return res;
  endfunction

  // Idle cycles before the next transaction; often none
  function automatic int draw_wait(bit enable);
    if (!enable || $urandom_range(0, 2) == 0) return 0;
    return $urandom_range(0, 17);
  endfunction

  function automatic int ticks_to_expire(logic [15:0] count);
    return (count == 16'd0) ? 1 : int'(count);
  endfunction

  task automatic send_byte(logic [7:0] ch);
    acc_pkg::in_t item;
    item.cmd = 1'b0;
    item.rx_byte = ch;
    queued_commands.push_back(item);
    queued_total++;
  endtask

  // Ticks, optionally mixed with bytes that a busy controller drops
  task automatic send_ticks(int n, bit with_drops);
    acc_pkg::in_t item;
    repeat (n) begin
      if (with_drops && $urandom_range(0, 4) == 0) send_byte(8'($urandom));
      item.cmd = 1'b1;
      item.rx_byte = 8'($urandom);  // ignored on a tick
      queued_commands.push_back(item);
      queued_total++;
    end
  endtask

  // Sampled at the falling edge so the driver's updates have settled
  task automatic wait_drained();
    do @(negedge clk);
    while (queued_commands.size() != 0 || in_valid || predicted_outputs.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == acc_pkg::CFG_PULSE_TICKS) pulse_len = value;
    else gap_len = value;
  endtask

  // Bring the controller back to idle from whatever state it was left in
  task automatic return_to_idle();
    wait_drained();
    case (ctrl_mode)
      acc_pkg::MODE_AUTO: send_byte(acc_pkg::CH_EXIT);
      acc_pkg::MODE_MANUAL: begin
        if (pulse_sel != acc_pkg::TGT_NONE) send_ticks(ticks_to_expire(remaining), 1'b1);
        send_byte(acc_pkg::CH_EXIT);
        send_ticks(2 * ticks_to_expire(gap_len), 1'b1);
      end
      acc_pkg::MODE_SHUTDOWN: begin
        send_ticks(ticks_to_expire(remaining), 1'b1);
        if (sd_stage == acc_pkg::SD_SPIST) send_ticks(ticks_to_expire(gap_len), 1'b1);
      end
      default: ;
    endcase
    wait_drained();
  endtask

  // Input driver: one queued command per transaction, random gaps between them
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) predicted_outputs.push_back(advance_controller(in_data));
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (queued_commands.size() != 0) begin
          in_data <= queued_commands.pop_front();
          in_valid <= 1'b1;
          gap_left <= draw_wait(drive_idle);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: check each result, then stall a random number of cycles
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && out_ready) begin
      result_count++;
      if (predicted_outputs.size() == 0) begin
        error_count++;
        if (error_count <= 10) $display("result %0d arrived with none expected: %p",
                                        result_count, out_data);
      end else begin
        want = predicted_outputs.pop_front();
        if (want !== out_data) begin
          error_count++;
          if (error_count <= 10) begin
            $write("result %0d mismatch (expected/actual): echo_valid %0b/%0b ",
                   result_count, want.echo_valid, out_data.echo_valid);
            $write("echo_byte %02h/%02h suction %0b/%0b ", want.echo_byte,
                   out_data.echo_byte, want.suction_on, out_data.suction_on);
            $display("suction_piston %0b/%0b label_piston %0b/%0b mode %0d/%0d",
                     want.suction_piston_on, out_data.suction_piston_on,
                     want.label_piston_on, out_data.label_piston_on,
                     want.mode, out_data.mode);
          end
        end
      end
      next_stall = draw_wait(accept_idle);
      if (next_stall != 0) begin
        out_ready <= 1'b0;
        stall_left <= next_stall - 1;
      end
    end else if (!out_ready) begin
      if (stall_left != 0) stall_left <= stall_left - 1;
      else out_ready <= 1'b1;
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int first;
    int random_items;
    int kind;
    int pick;
    logic [7:0] ch;
    random_items = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Idle echoes everything, byte extremes and command letters included
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(acc_pkg::CH_SET_SUCT);
    send_ticks(1, 1'b0);
    send_byte(acc_pkg::CH_AUTO);
    // Automatic: set all, ignore stray bytes and ticks, clear all, exit with two on
    send_byte(acc_pkg::CH_SET_SUCT);
    send_byte(acc_pkg::CH_SET_SPIST);
    send_byte(acc_pkg::CH_SET_LPIST);
    send_byte(acc_pkg::CH_MANUAL);
    send_ticks(1, 1'b0);
    send_byte(acc_pkg::CH_CLR_SUCT);
    send_byte(acc_pkg::CH_CLR_SPIST);
    send_byte(acc_pkg::CH_CLR_LPIST);
    send_byte(acc_pkg::CH_SET_LPIST);
    send_byte(acc_pkg::CH_SET_SUCT);
    send_byte(acc_pkg::CH_EXIT);
    wait_drained();

    // Manual with a short pulse length and gap; outputs kept from automatic mode
    write_cfg(acc_pkg::CFG_PULSE_TICKS, 16'd4);
    write_cfg(acc_pkg::CFG_SHUTDOWN_GAP_TICKS, 16'd3);
    send_byte(acc_pkg::CH_MANUAL);
    send_byte(8'h3F);
    send_ticks(1, 1'b0);
    send_byte(acc_pkg::CH_SET_SPIST);
    send_ticks(ticks_to_expire(pulse_len), 1'b1);
    send_byte(acc_pkg::CH_EXIT);
    send_ticks(2 * ticks_to_expire(gap_len), 1'b1);
    wait_drained();

    // Zero count behaves as one tick
    write_cfg(acc_pkg::CFG_PULSE_TICKS, 16'd0);
    write_cfg(acc_pkg::CFG_SHUTDOWN_GAP_TICKS, 16'd0);
    send_byte(acc_pkg::CH_MANUAL);
    send_byte(acc_pkg::CH_SET_SUCT);
    send_ticks(1, 1'b0);
    send_byte(acc_pkg::CH_EXIT);
    send_ticks(2, 1'b0);
    wait_drained();

    // A new pulse length leaves a running pulse alone
    write_cfg(acc_pkg::CFG_PULSE_TICKS, 16'd5);
    send_byte(acc_pkg::CH_MANUAL);
    send_byte(acc_pkg::CH_SET_LPIST);
    wait_drained();
    write_cfg(acc_pkg::CFG_PULSE_TICKS, 16'd1);
    send_ticks(5, 1'b0);
    send_byte(acc_pkg::CH_EXIT);
    send_ticks(2, 1'b0);
    return_to_idle();

    // Random phases: short counts, well-formed sessions, some noise at the end
    while (random_items < RANDOM_ITEMS) begin
      first = queued_total;
      if ($urandom_range(0, 1))
        write_cfg(acc_pkg::CFG_PULSE_TICKS,
                  ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 6)));
      if ($urandom_range(0, 1))
        write_cfg(acc_pkg::CFG_SHUTDOWN_GAP_TICKS,
                  ($urandom_range(0, 9) == 0) ? 16'd0 : 16'($urandom_range(1, 6)));
      drive_idle = ($urandom_range(0, 3) != 0);
      accept_idle = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(3, 8)) begin
        kind = $urandom_range(0, 19);
        if (kind <= 6) begin
          // automatic session
          send_byte(acc_pkg::CH_AUTO);
          repeat ($urandom_range(1, 20)) begin
            pick = $urandom_range(0, 9);
            if (pick <= 5) begin
              send_byte(AUTO_CHARS[$urandom_range(0, 5)]);
            end else if (pick == 6) begin
              send_ticks(1, 1'b0);
            end else if (pick == 7) begin
              send_byte($urandom_range(0, 1) ? acc_pkg::CH_MANUAL : acc_pkg::CH_AUTO);
            end else begin
              do ch = 8'($urandom); while (ch == acc_pkg::CH_EXIT);
              send_byte(ch);
            end
          end
          send_byte(acc_pkg::CH_EXIT);
        end else if (kind <= 15) begin
          // manual session: pulses run to their end, then the staged shutdown
          send_byte(acc_pkg::CH_MANUAL);
          repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 9) < 7) begin
              send_byte(PULSE_CHARS[$urandom_range(0, 2)]);
              send_ticks(ticks_to_expire(pulse_len), 1'b1);
            end else if ($urandom_range(0, 1)) begin
              send_ticks(1, 1'b0);
            end else begin
              do ch = 8'($urandom);
              while (ch == acc_pkg::CH_SET_SUCT || ch == acc_pkg::CH_SET_SPIST ||
                     ch == acc_pkg::CH_SET_LPIST || ch == acc_pkg::CH_EXIT);
              send_byte(ch);
            end
          end
          send_byte(acc_pkg::CH_EXIT);
          send_ticks(2 * ticks_to_expire(gap_len), 1'b1);
        end else begin
          // idle traffic that stays idle
          repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 2) == 0) begin
              send_ticks(1, 1'b0);
            end else begin
              do ch = 8'($urandom);
              while (ch == acc_pkg::CH_AUTO || ch == acc_pkg::CH_MANUAL);
              send_byte(ch);
            end
          end
        end
      end
      // broken sequences: random commands from idle, left wherever they end
      if ($urandom_range(0, 2) == 0) begin
        if ($urandom_range(0, 1))
          send_byte($urandom_range(0, 1) ? acc_pkg::CH_MANUAL : acc_pkg::CH_AUTO);
        repeat ($urandom_range(1, 12)) begin
          pick = $urandom_range(0, 5);
          if (pick <= 1) send_ticks(1, 1'b0);
          else if (pick <= 3) send_byte(8'($urandom));
          else if (pick == 4) send_byte(AUTO_CHARS[$urandom_range(0, 5)]);
          else send_byte(acc_pkg::CH_EXIT);
        end
      end
      random_items += queued_total - first;
      return_to_idle();
    end

    if (error_count == 0 && predicted_outputs.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
sv/acc_pkg.sv
sv/acc_cfg.sv
sv/acc_step.sv
sv/actuator_command_controller.sv
bench/tb.sv
